### hw/rtl/i2c_status_transfer_sequencer_assert.svh
// Assertion macros shared by the I2C status transfer sequencer RTL.
`ifndef I2C_STATUS_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_STATUS_TRANSFER_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define ISTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define ISTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ists_pkg.sv
// Types and constants of the I2C status transfer sequencer.
`default_nettype none

package ists_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_SIZE0     = 3'd1,
    RC_ADDR_NACK = 3'd2,
    RC_DATA_NACK = 3'd3,
    RC_STOP_RX   = 3'd4,
    RC_UNSUPP    = 3'd5,
    RC_UNKNOWN   = 3'd6
  } result_e;

  // Control register bits of the core.
  localparam logic [6:0] CtlAa  = 7'h04;
  localparam logic [6:0] CtlSi  = 7'h08;
  localparam logic [6:0] CtlSto = 7'h10;
  localparam logic [6:0] CtlSta = 7'h20;

  // Status codes reported by the core.
  localparam logic [7:0] StBusErr    = 8'h00;
  localparam logic [7:0] StStart     = 8'h08;
  localparam logic [7:0] StRestart   = 8'h10;
  localparam logic [7:0] StMtAddrAck = 8'h18;
  localparam logic [7:0] StMtAddrNak = 8'h20;
  localparam logic [7:0] StMtDataAck = 8'h28;
  localparam logic [7:0] StMtDataNak = 8'h30;
  localparam logic [7:0] StArbLost   = 8'h38;
  localparam logic [7:0] StMrAddrAck = 8'h40;
  localparam logic [7:0] StMrAddrNak = 8'h48;
  localparam logic [7:0] StMrDataAck = 8'h50;
  localparam logic [7:0] StMrDataNak = 8'h58;
  localparam logic [7:0] StSrAddr    = 8'h60;
  localparam logic [7:0] StSrArbAddr = 8'h68;
  localparam logic [7:0] StSrGen     = 8'h70;
  localparam logic [7:0] StSrArbGen  = 8'h78;
  localparam logic [7:0] StSrDataAck = 8'h80;
  localparam logic [7:0] StSrDataNak = 8'h88;
  localparam logic [7:0] StSrGenAck  = 8'h90;
  localparam logic [7:0] StSrGenNak  = 8'h98;
  localparam logic [7:0] StSrStop    = 8'hA0;
  localparam logic [7:0] StStAddr    = 8'hA8;
  localparam logic [7:0] StStArbAddr = 8'hB0;
  localparam logic [7:0] StStDataAck = 8'hB8;
  localparam logic [7:0] StStDataNak = 8'hC0;
  localparam logic [7:0] StStLastAck = 8'hC8;
  localparam logic [7:0] StIdle      = 8'hF8;

endpackage

`default_nettype wire

### hw/rtl/ists_if.sv
// Channel interfaces of the I2C status transfer sequencer.
`default_nettype none

interface ists_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] slave_addr;
  logic [7:0] byte_count;
  logic       send_stop;
  logic [7:0] status_code;
  logic [7:0] rx_byte;
  logic [7:0] tx_byte;

  modport source (output valid, cmd, slave_addr, byte_count, send_stop, status_code,
                  rx_byte, tx_byte, input ready);
  modport sink (input valid, cmd, slave_addr, byte_count, send_stop, status_code,
                rx_byte, tx_byte, output ready);
endinterface

interface ists_out_if;
  logic              valid;
  logic              ready;
  logic              dat_write;
  logic [7:0]        dat_value;
  logic [6:0]        set_mask;
  logic [6:0]        clear_mask;
  logic              rx_valid;
  logic [7:0]        rx_data;
  logic              done_res;
  ists_pkg::result_e result_code;
  logic [7:0]        moved_count;

  modport source (output valid, dat_write, dat_value, set_mask, clear_mask, rx_valid,
                  rx_data, done_res, result_code, moved_count, input ready);
  modport sink (input valid, dat_write, dat_value, set_mask, clear_mask, rx_valid,
                rx_data, done_res, result_code, moved_count, output ready);
endinterface

interface ists_cfg_if;
  logic valid;
  logic ready;
  logic master_mode;

  modport source (output valid, master_mode, input ready);
  modport sink (input valid, master_mode, output ready);
endinterface

`default_nettype wire

### hw/rtl/i2c_status_transfer_sequencer.sv
// Top level of the I2C status transfer sequencer: decodes core status events into actions.
//
//   channel  | dir | word
//   ---------+-----+-------------------------------------------------------------
//   in_i     | in  | begin write/read or status event, with address, count, bytes
//   out_o    | out | data write, control set/clear masks, rx byte, finish code
//   cfg_i    | in  | master_mode bit
//
// An accepted word is captured in the input register, then its result lands in
// the output register, from which it is offered.
// One word per cycle is sustained while the output accepts; a stall holds the flow.
// A stalled output holds its word and stops the input register only once it is full.
// Reset leaves the sequencer idle with master_mode set; configuration is always ready.
`default_nettype none

`include "i2c_status_transfer_sequencer_assert.svh"

module i2c_status_transfer_sequencer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ists_in_if.sink     in_i,
  ists_out_if.source  out_o,
  ists_cfg_if.sink    cfg_i
);

  typedef enum logic [2:0] {
    XS_IDLE  = 3'b001,
    XS_WRITE = 3'b010,
    XS_READ  = 3'b100
  } xfer_state_e;

  typedef struct packed {
    logic              dat_write;
    logic [7:0]        dat_value;
    logic [6:0]        set_mask;
    logic [6:0]        clear_mask;
    logic              rx_valid;
    logic [7:0]        rx_data;
    logic              done_res;
    ists_pkg::result_e result_code;
    logic [7:0]        moved_count;
  } out_word_t;

  // Transfer state.
  xfer_state_e state_q, state_d;
  logic [7:0]  target_addr_q, target_addr_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [7:0]  transferred_q, transferred_d;
  logic        stop_after_q, stop_after_d;
  logic        master_mode_q;

  // Input register.
  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] slave_addr_q;
  logic [7:0] byte_count_q;
  logic       send_stop_q;
  logic [7:0] status_q;
  logic [7:0] rx_byte_q;
  logic [7:0] tx_byte_q;

  // Output register.
  logic      out_valid_q;
  out_word_t res_q, res_d;

  logic       advance;
  logic [7:0] rem_dec;
  logic [7:0] xfer_inc;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign rem_dec     = remaining_q - 8'd1;
  assign xfer_inc    = transferred_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q        <= in_i.cmd;
      slave_addr_q <= in_i.slave_addr;
      byte_count_q <= in_i.byte_count;
      send_stop_q  <= in_i.send_stop;
      status_q     <= in_i.status_code;
      rx_byte_q    <= in_i.rx_byte;
      tx_byte_q    <= in_i.tx_byte;
    end
  end

  always_comb begin
    res_d         = '0;
    state_d       = state_q;
    target_addr_d = target_addr_q;
    remaining_d   = remaining_q;
    transferred_d = transferred_q;
    stop_after_d  = stop_after_q;

    case (cmd_q)
      ists_pkg::CMD_WRITE, ists_pkg::CMD_READ: begin
        // A begin word opens a new transfer and drops any open one.
        state_d       = (cmd_q == ists_pkg::CMD_READ) ? XS_READ : XS_WRITE;
        target_addr_d = slave_addr_q;
        remaining_d   = byte_count_q;
        transferred_d = '0;
        stop_after_d  = send_stop_q;
      end
      ists_pkg::CMD_EVENT: begin
        case (state_q)
          XS_WRITE: begin
            case (status_q)
              ists_pkg::StIdle: res_d.set_mask = ists_pkg::CtlSta;
              ists_pkg::StStart, ists_pkg::StRestart: begin
                res_d.dat_write  = 1'b1;
                res_d.dat_value  = target_addr_q;
                res_d.clear_mask = ists_pkg::CtlSi;
              end
              ists_pkg::StMtAddrAck: begin
                if (remaining_q == 8'd0) begin
                  res_d.set_mask    = ists_pkg::CtlSto;
                  res_d.clear_mask  = ists_pkg::CtlSi;
                  res_d.done_res    = 1'b1;
                  res_d.result_code = ists_pkg::RC_SIZE0;
                  state_d           = XS_IDLE;
                end else begin
                  res_d.dat_write  = 1'b1;
                  res_d.dat_value  = tx_byte_q;
                  remaining_d      = rem_dec;
                  transferred_d    = xfer_inc;
                  res_d.clear_mask = ists_pkg::CtlSta | ists_pkg::CtlSi;
                end
              end
              ists_pkg::StMtAddrNak: begin
                res_d.set_mask    = ists_pkg::CtlSto;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_ADDR_NACK;
                state_d           = XS_IDLE;
              end
              ists_pkg::StMtDataAck: begin
                if (remaining_q == 8'd0) begin
                  res_d.set_mask    = stop_after_q ? ists_pkg::CtlSto : ists_pkg::CtlSta;
                  res_d.clear_mask  = ists_pkg::CtlSi;
                  res_d.done_res    = 1'b1;
                  res_d.result_code = ists_pkg::RC_OK;
                  res_d.moved_count = transferred_q;
                  state_d           = XS_IDLE;
                end else begin
                  res_d.dat_write  = 1'b1;
                  res_d.dat_value  = tx_byte_q;
                  remaining_d      = rem_dec;
                  transferred_d    = xfer_inc;
                  res_d.clear_mask = ists_pkg::CtlSi;
                end
              end
              ists_pkg::StMtDataNak: begin
                res_d.set_mask    = ists_pkg::CtlSto;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_DATA_NACK;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StArbLost: begin
                res_d.set_mask   = ists_pkg::CtlSta;
                res_d.clear_mask = ists_pkg::CtlSi;
              end
              ists_pkg::StStAddr: begin
                res_d.dat_write = 1'b1;
                res_d.dat_value = tx_byte_q;
                remaining_d     = rem_dec;
                transferred_d   = xfer_inc;
                // The last byte goes out without acknowledge expected afterwards.
                if (rem_dec == 8'd0) begin
                  res_d.clear_mask = ists_pkg::CtlAa | ists_pkg::CtlSi;
                end else begin
                  res_d.set_mask   = ists_pkg::CtlAa;
                  res_d.clear_mask = ists_pkg::CtlSi;
                end
              end
              ists_pkg::StStArbAddr: begin
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_UNSUPP;
                res_d.moved_count = status_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StStDataAck: begin
                res_d.dat_write  = 1'b1;
                res_d.dat_value  = tx_byte_q;
                remaining_d      = rem_dec;
                transferred_d    = xfer_inc;
                res_d.set_mask   = ists_pkg::CtlAa;
                res_d.clear_mask = ists_pkg::CtlSi;
              end
              ists_pkg::StStDataNak, ists_pkg::StStLastAck: begin
                res_d.set_mask    = ists_pkg::CtlAa;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_OK;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StBusErr: begin
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_UNKNOWN;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              default: ;
            endcase
          end
          XS_READ: begin
            case (status_q)
              ists_pkg::StIdle: begin
                if (master_mode_q) res_d.set_mask = ists_pkg::CtlSta;
              end
              ists_pkg::StStart, ists_pkg::StRestart: begin
                res_d.dat_write  = 1'b1;
                res_d.dat_value  = target_addr_q | 8'h01;
                res_d.clear_mask = ists_pkg::CtlSi;
              end
              ists_pkg::StMrAddrAck: begin
                if (remaining_q > 8'd1) res_d.set_mask = ists_pkg::CtlAa;
                res_d.clear_mask = ists_pkg::CtlSta | ists_pkg::CtlSi;
              end
              ists_pkg::StMrAddrNak: begin
                res_d.set_mask    = ists_pkg::CtlSto;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_ADDR_NACK;
                state_d           = XS_IDLE;
              end
              ists_pkg::StMrDataAck: begin
                res_d.rx_valid = 1'b1;
                res_d.rx_data  = rx_byte_q;
                remaining_d    = rem_dec;
                transferred_d  = xfer_inc;
                // Acknowledge only while more than the final byte is still due.
                if (rem_dec > 8'd1) begin
                  res_d.set_mask   = ists_pkg::CtlAa;
                  res_d.clear_mask = ists_pkg::CtlSi;
                end else begin
                  res_d.clear_mask = ists_pkg::CtlAa | ists_pkg::CtlSi;
                end
              end
              ists_pkg::StMrDataNak: begin
                res_d.rx_valid    = 1'b1;
                res_d.rx_data     = rx_byte_q;
                transferred_d     = xfer_inc;
                res_d.set_mask    = stop_after_q ? ists_pkg::CtlSto : ists_pkg::CtlSta;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_OK;
                res_d.moved_count = xfer_inc;
                state_d           = XS_IDLE;
              end
              ists_pkg::StSrAddr: begin
                res_d.set_mask   = ists_pkg::CtlAa;
                res_d.clear_mask = ists_pkg::CtlSi;
              end
              ists_pkg::StSrArbAddr, ists_pkg::StSrGen, ists_pkg::StSrArbGen,
              ists_pkg::StSrGenAck, ists_pkg::StSrGenNak: begin
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_UNSUPP;
                res_d.moved_count = status_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StSrDataAck: begin
                res_d.rx_valid = 1'b1;
                res_d.rx_data  = rx_byte_q;
                remaining_d    = rem_dec;
                transferred_d  = xfer_inc;
                if (rem_dec == 8'd0) begin
                  res_d.clear_mask = ists_pkg::CtlAa | ists_pkg::CtlSi;
                end else begin
                  res_d.set_mask   = ists_pkg::CtlAa;
                  res_d.clear_mask = ists_pkg::CtlSi;
                end
              end
              ists_pkg::StSrDataNak: begin
                res_d.set_mask    = ists_pkg::CtlAa;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_OK;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StSrStop: begin
                res_d.set_mask    = ists_pkg::CtlAa;
                res_d.clear_mask  = ists_pkg::CtlSi;
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_STOP_RX;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              ists_pkg::StBusErr: begin
                res_d.done_res    = 1'b1;
                res_d.result_code = ists_pkg::RC_UNKNOWN;
                res_d.moved_count = transferred_q;
                state_d           = XS_IDLE;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= XS_IDLE;
      target_addr_q <= '0;
      remaining_q   <= '0;
      transferred_q <= '0;
      stop_after_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q       <= state_d;
        target_addr_q <= target_addr_d;
        remaining_q   <= remaining_d;
        transferred_q <= transferred_d;
        stop_after_q  <= stop_after_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_mode_q <= 1'b1;
    end else if (cfg_i.valid) begin
      master_mode_q <= cfg_i.master_mode;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dat_write   = res_q.dat_write;
  assign out_o.dat_value   = res_q.dat_value;
  assign out_o.set_mask    = res_q.set_mask;
  assign out_o.clear_mask  = res_q.clear_mask;
  assign out_o.rx_valid    = res_q.rx_valid;
  assign out_o.rx_data     = res_q.rx_data;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.result_code = res_q.result_code;
  assign out_o.moved_count = res_q.moved_count;

  `ISTS_ASSERT_NXT(a_finish_goes_idle, advance && in_valid_q && res_d.done_res,
                   state_q == XS_IDLE, "finishing word left the transfer open")
  `ISTS_ASSERT_NXT(a_begin_opens, advance && in_valid_q &&
                   (cmd_q == ists_pkg::CMD_WRITE || cmd_q == ists_pkg::CMD_READ),
                   state_q != XS_IDLE && transferred_q == 8'd0,
                   "begin word did not open a transfer")
  `ISTS_ASSERT_IMP(a_idle_event_quiet, in_valid_q && state_q == XS_IDLE &&
                   cmd_q == ists_pkg::CMD_EVENT, res_d == '0,
                   "event while idle produced an action")
  `ISTS_ASSERT_IMP(a_open_result_clean, out_o.valid && !out_o.done_res,
                   out_o.result_code == ists_pkg::RC_OK && out_o.moved_count == 8'd0,
                   "unfinished word carries a finish code")

endmodule

`default_nettype wire

### tb/i2c_status_transfer_sequencer_test.sv
// Self-checking testbench for the I2C status transfer sequencer, with a scoreboard class.
module i2c_status_transfer_sequencer_test;
  import ists_pkg::*;

  // A command code outside the defined set; the block must ignore it.
  localparam logic [1:0] CmdIgnored = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slave_addr;
    logic [7:0] byte_count;
    logic       send_stop;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } xfer_word_t;

  typedef struct packed {
    logic       dat_write;
    logic [7:0] dat_value;
    logic [6:0] set_mask;
    logic [6:0] clear_mask;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [2:0] result_code;
    logic [7:0] moved_count;
  } action_t;

  class action_scoreboard;
    action_t    pending_actions[$];
    bit         mode_q;
    bit         xfer_open;
    bit         xfer_read;
    bit         stop_q;
    logic [7:0] addr_q;
    logic [7:0] left_cnt;
    logic [7:0] moved_cnt;
    int         words_seen;
    int         actions_checked;
    int         finishes;
    int         errors;

    function new();
      mode_q    = 1'b1;
      xfer_open = 1'b0;
      xfer_read = 1'b0;
      stop_q    = 1'b0;
      addr_q    = '0;
      left_cnt  = '0;
      moved_cnt = '0;
    endfunction

    function void set_mode(bit m);
      mode_q = m;
    endfunction

    function int pending();
      return pending_actions.size();
    endfunction

    function void take_byte();
      left_cnt  = left_cnt - 8'd1;
      moved_cnt = moved_cnt + 8'd1;
    endfunction

    function void close_xfer(inout action_t a, input result_e code, input logic [7:0] cnt);
      a.done_res    = 1'b1;
      a.result_code = code;
      a.moved_count = cnt;
      xfer_open     = 1'b0;
    endfunction

    function void write_event(inout action_t a, input logic [7:0] st, input logic [7:0] txb);
      case (st)
        StIdle: a.set_mask = CtlSta;
        StStart, StRestart: begin
          a.dat_write  = 1'b1;
          a.dat_value  = addr_q;
          a.clear_mask = CtlSi;
        end
        StMtAddrAck: begin
          if (left_cnt == 8'd0) begin
            a.set_mask   = CtlSto;
            a.clear_mask = CtlSi;
            close_xfer(a, RC_SIZE0, 8'd0);
          end else begin
            a.dat_write  = 1'b1;
            a.dat_value  = txb;
            take_byte();
            a.clear_mask = CtlSta | CtlSi;
          end
        end
        StMtAddrNak: begin
          a.set_mask   = CtlSto;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_ADDR_NACK, 8'd0);
        end
        StMtDataAck: begin
          if (left_cnt == 8'd0) begin
            a.set_mask   = stop_q ? CtlSto : CtlSta;
            a.clear_mask = CtlSi;
            close_xfer(a, RC_OK, moved_cnt);
          end else begin
            a.dat_write  = 1'b1;
            a.dat_value  = txb;
            take_byte();
            a.clear_mask = CtlSi;
          end
        end
        StMtDataNak: begin
          a.set_mask   = CtlSto;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_DATA_NACK, moved_cnt);
        end
        StArbLost: begin
          a.set_mask   = CtlSta;
          a.clear_mask = CtlSi;
        end
        StStAddr: begin
          a.dat_write = 1'b1;
          a.dat_value = txb;
          take_byte();
          if (left_cnt == 8'd0) begin
            a.clear_mask = CtlAa | CtlSi;
          end else begin
            a.set_mask   = CtlAa;
            a.clear_mask = CtlSi;
          end
        end
        StStArbAddr: close_xfer(a, RC_UNSUPP, st);
        StStDataAck: begin
          a.dat_write  = 1'b1;
          a.dat_value  = txb;
          take_byte();
          a.set_mask   = CtlAa;
          a.clear_mask = CtlSi;
        end
        StStDataNak, StStLastAck: begin
          a.set_mask   = CtlAa;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_OK, moved_cnt);
        end
        StBusErr: close_xfer(a, RC_UNKNOWN, moved_cnt);
        default: ;
      endcase
    endfunction

    function void read_event(inout action_t a, input logic [7:0] st, input logic [7:0] rxb);
      case (st)
        StIdle: if (mode_q) a.set_mask = CtlSta;
        StStart, StRestart: begin
          a.dat_write  = 1'b1;
          a.dat_value  = addr_q | 8'h01;
          a.clear_mask = CtlSi;
        end
        StMrAddrAck: begin
          if (left_cnt > 8'd1) a.set_mask = CtlAa;
          a.clear_mask = CtlSta | CtlSi;
        end
        StMrAddrNak: begin
          a.set_mask   = CtlSto;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_ADDR_NACK, 8'd0);
        end
        StMrDataAck: begin
          a.rx_valid = 1'b1;
          a.rx_data  = rxb;
          take_byte();
          if (left_cnt > 8'd1) begin
            a.set_mask   = CtlAa;
            a.clear_mask = CtlSi;
          end else begin
            a.clear_mask = CtlAa | CtlSi;
          end
        end
        StMrDataNak: begin
          // The last byte counts even though the slave was not acknowledged.
          a.rx_valid   = 1'b1;
          a.rx_data    = rxb;
          moved_cnt    = moved_cnt + 8'd1;
          a.set_mask   = stop_q ? CtlSto : CtlSta;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_OK, moved_cnt);
        end
        StSrAddr: begin
          a.set_mask   = CtlAa;
          a.clear_mask = CtlSi;
        end
        StSrArbAddr, StSrGen, StSrArbGen, StSrGenAck, StSrGenNak:
          close_xfer(a, RC_UNSUPP, st);
        StSrDataAck: begin
          a.rx_valid = 1'b1;
          a.rx_data  = rxb;
          take_byte();
          if (left_cnt == 8'd0) begin
            a.clear_mask = CtlAa | CtlSi;
          end else begin
            a.set_mask   = CtlAa;
            a.clear_mask = CtlSi;
          end
        end
        StSrDataNak: begin
          a.set_mask   = CtlAa;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_OK, moved_cnt);
        end
        StSrStop: begin
          a.set_mask   = CtlAa;
          a.clear_mask = CtlSi;
          close_xfer(a, RC_STOP_RX, moved_cnt);
        end
        StBusErr: close_xfer(a, RC_UNKNOWN, moved_cnt);
        default: ;
      endcase
    endfunction

    function action_t predict_action(xfer_word_t w);
      action_t a;
      a = '0;
      if (w.cmd == CMD_WRITE || w.cmd == CMD_READ) begin
        xfer_open = 1'b1;
        xfer_read = (w.cmd == CMD_READ);
        addr_q    = w.slave_addr;
        left_cnt  = w.byte_count;
        moved_cnt = 8'd0;
        stop_q    = w.send_stop;
      end else if (w.cmd == CMD_EVENT && xfer_open) begin
        if (xfer_read) read_event(a, w.status_code, w.rx_byte);
        else write_event(a, w.status_code, w.tx_byte);
      end
      return a;
    endfunction

    function void note_word(xfer_word_t w);
      words_seen++;
      pending_actions.push_back(predict_action(w));
    endfunction

    function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
      if (got === want) return 1'b0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    endfunction

    function void check_action(action_t act);
      action_t want;
      bit      bad;
      if (pending_actions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %0h", $time, act);
        return;
      end
      want = pending_actions.pop_front();
      actions_checked++;
      if (want.done_res) finishes++;
      bad = 1'b0;
      bad |= field_differs("dat_write", 8'(want.dat_write), 8'(act.dat_write));
      bad |= field_differs("dat_value", want.dat_value, act.dat_value);
      bad |= field_differs("set_mask", 8'(want.set_mask), 8'(act.set_mask));
      bad |= field_differs("clear_mask", 8'(want.clear_mask), 8'(act.clear_mask));
      bad |= field_differs("rx_valid", 8'(want.rx_valid), 8'(act.rx_valid));
      bad |= field_differs("rx_data", want.rx_data, act.rx_data);
      bad |= field_differs("done_res", 8'(want.done_res), 8'(act.done_res));
      bad |= field_differs("result_code", 8'(want.result_code), 8'(act.result_code));
      bad |= field_differs("moved_count", want.moved_count, act.moved_count);
      if (bad) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ists_in_if  in_ch();
  ists_out_if out_ch();
  ists_cfg_if cfg_ch();

  i2c_status_transfer_sequencer u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  action_scoreboard sb;
  action_t          got_action;
  bit               steady = 1'b0;
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;

  logic [7:0] wr_codes [13] = '{StIdle, StStart, StRestart, StMtAddrAck, StMtAddrNak,
                                StMtDataAck, StMtDataNak, StArbLost, StStAddr, StStArbAddr,
                                StStDataAck, StStDataNak, StStLastAck};
  logic [7:0] rd_codes [17] = '{StIdle, StStart, StRestart, StMrAddrAck, StMrAddrNak,
                                StMrDataAck, StMrDataNak, StSrAddr, StSrArbAddr, StSrGen,
                                StSrArbGen, StSrDataAck, StSrDataNak, StSrGenAck, StSrGenNak,
                                StSrStop, StStAddr};

  function automatic xfer_word_t rand_word(logic [1:0] cmd);
    xfer_word_t w;
    w.cmd         = cmd;
    w.slave_addr  = 8'($urandom_range(0, 255));
    w.byte_count  = 8'($urandom_range(0, 255));
    w.send_stop   = 1'($urandom_range(0, 1));
    w.status_code = 8'($urandom_range(0, 255));
    w.rx_byte     = 8'($urandom_range(0, 255));
    w.tx_byte     = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic xfer_word_t mk_begin(logic [1:0] cmd, logic [7:0] addr,
                                          logic [7:0] cnt, logic stop);
    xfer_word_t w;
    w            = rand_word(cmd);
    w.slave_addr = addr;
    w.byte_count = cnt;
    w.send_stop  = stop;
    return w;
  endfunction

  function automatic xfer_word_t mk_event(logic [7:0] st, logic [7:0] rxb, logic [7:0] txb);
    xfer_word_t w;
    w             = rand_word(CMD_EVENT);
    w.status_code = st;
    w.rx_byte     = rxb;
    w.tx_byte     = txb;
    return w;
  endfunction

  // Mostly follows the status order a real bus would report, with some stray codes.
  function automatic logic [7:0] pick_status(bit rd, bit slave, int step, int cnt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'($urandom_range(0, 255));
    if (r < 8) return StBusErr;
    if (r < 25) begin
      return rd ? rd_codes[5'($urandom_range(0, 16))] : wr_codes[4'($urandom_range(0, 12))];
    end
    if (!rd && !slave) begin
      case (step)
        0: return StIdle;
        1: return StStart;
        2: return StMtAddrAck;
        default: return (r < 30) ? StMtDataNak : StMtDataAck;
      endcase
    end
    if (!rd) begin
      if (step == 0) return StStAddr;
      if (step <= cnt) return StStDataAck;
      return (r < 60) ? StStLastAck : StStDataNak;
    end
    if (!slave) begin
      case (step)
        0: return StIdle;
        1: return StRestart;
        2: return StMrAddrAck;
        default: return (step < cnt + 2) ? StMrDataAck : StMrDataNak;
      endcase
    end
    if (step == 0) return StSrAddr;
    if (step <= cnt) return StSrDataAck;
    return (r < 60) ? StSrStop : StSrDataNak;
  endfunction

  task automatic send_word(xfer_word_t w);
    @(negedge clk_i);
    if (!steady && !calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_ch.cmd         = w.cmd;
    in_ch.slave_addr  = w.slave_addr;
    in_ch.byte_count  = w.byte_count;
    in_ch.send_stop   = w.send_stop;
    in_ch.status_code = w.status_code;
    in_ch.rx_byte     = w.rx_byte;
    in_ch.tx_byte     = w.tx_byte;
    in_ch.valid       = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_word(w);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.master_mode = m;
    cfg_ch.valid       = 1'b1;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    sb.set_mode(m);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_directed();
    send_word(mk_event(StMtAddrAck, 8'hFF, 8'hFF));
    send_word(rand_word(CmdIgnored));
    send_word(mk_begin(CMD_WRITE, 8'hFF, 8'd1, 1'b1));
    send_word(mk_event(StIdle, 8'h00, 8'h00));
    send_word(mk_event(StStart, 8'h00, 8'h00));
    send_word(mk_event(StMtAddrAck, 8'hFF, 8'h00));
    send_word(mk_event(StMtDataAck, 8'h00, 8'hFF));
    send_word(mk_begin(CMD_WRITE, 8'h00, 8'd0, 1'b0));
    send_word(mk_event(StMtAddrAck, 8'h5A, 8'hA5));
    // A slave transmit with nothing left wraps the byte counter.
    send_word(mk_begin(CMD_WRITE, 8'h5A, 8'd0, 1'b0));
    send_word(mk_event(StStAddr, 8'h00, 8'h3C));
    send_word(mk_event(StStArbAddr, 8'h00, 8'h00));
    send_word(mk_begin(CMD_READ, 8'hFE, 8'd2, 1'b0));
    send_word(mk_event(StMrAddrAck, 8'h00, 8'h00));
    send_word(mk_event(StMrDataAck, 8'hFF, 8'h00));
    send_word(mk_event(StMrDataNak, 8'h00, 8'hFF));
    send_word(mk_begin(CMD_READ, 8'h81, 8'd0, 1'b1));
    send_word(mk_event(8'h55, 8'hAA, 8'h55));
    send_word(mk_event(StStAddr, 8'h11, 8'h22));
    send_word(mk_event(StSrAddr, 8'h00, 8'h00));
    send_word(mk_event(StSrDataAck, 8'hC3, 8'h00));
    send_word(mk_event(StSrStop, 8'h00, 8'h00));
    send_word(mk_begin(CMD_WRITE, 8'h42, 8'd3, 1'b1));
    send_word(mk_begin(CMD_READ, 8'h24, 8'd255, 1'b0));
    send_word(mk_event(StBusErr, 8'h00, 8'h00));
    send_word(mk_begin(CMD_WRITE, 8'h10, 8'd4, 1'b0));
    send_word(mk_event(StMtAddrNak, 8'h00, 8'h00));
    send_word(mk_begin(CMD_READ, 8'h20, 8'd4, 1'b1));
    send_word(mk_event(StMrAddrNak, 8'h00, 8'h00));
  endtask

  task automatic run_transfer();
    bit rd;
    bit slave;
    int cnt;
    int n_ev;
    rd    = 1'($urandom_range(0, 1));
    slave = ($urandom_range(0, 2) == 0);
    cnt   = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
    calm  = ($urandom_range(0, 3) == 0);
    n_ev  = (cnt > 7) ? 12 : cnt + 5;
    if ($urandom_range(0, 19) == 0) send_word(rand_word(CmdIgnored));
    send_word(mk_begin(rd ? CMD_READ : CMD_WRITE, 8'($urandom_range(0, 255)), 8'(cnt),
                       1'($urandom_range(0, 1))));
    for (int k = 0; k < n_ev; k++) begin
      send_word(mk_event(pick_status(rd, slave, k, cnt), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255))));
      // Now and then keep sending events after the transfer has closed.
      if (!sb.xfer_open && $urandom_range(0, 3) != 0) break;
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 48;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 3);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_action.dat_write   = out_ch.dat_write;
      got_action.dat_value   = out_ch.dat_value;
      got_action.set_mask    = out_ch.set_mask;
      got_action.clear_mask  = out_ch.clear_mask;
      got_action.rx_valid    = out_ch.rx_valid;
      got_action.rx_data     = out_ch.rx_data;
      got_action.done_res    = out_ch.done_res;
      got_action.result_code = out_ch.result_code;
      got_action.moved_count = out_ch.moved_count;
      sb.check_action(got_action);
    end
  end

  initial begin
    #400000;
    $display("** i2c_status_transfer_sequencer: FAILED **");
    $finish;
  end

  initial begin
    sb                 = new();
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_EVENT;
    in_ch.slave_addr   = '0;
    in_ch.byte_count   = '0;
    in_ch.send_stop    = 1'b0;
    in_ch.status_code  = '0;
    in_ch.rx_byte      = '0;
    in_ch.tx_byte      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.master_mode = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b1);
    run_directed();
    while (sb.words_seen < 270) run_transfer();

    // In slave mode the receiver also stalls for a long stretch to back up the input.
    write_mode(1'b0);
    hold_req = 1'b1;
    while (sb.words_seen < 520) run_transfer();

    write_mode(1'b1);
    while (sb.words_seen < 660) run_transfer();
    steady = 1'b1;
    while (sb.words_seen < 790) run_transfer();

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d input words and %0d checked results, %0d finished transfers,",
             sb.words_seen, sb.actions_checked, sb.finishes);
    $display("in master and slave mode, with random stalls and one long output hold-off.");
    if (sb.errors == 0) begin
      $display("** i2c_status_transfer_sequencer: PASSED **");
    end else begin
      $display("** i2c_status_transfer_sequencer: FAILED **");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ists_pkg.sv
hw/rtl/ists_if.sv
hw/rtl/i2c_status_transfer_sequencer.sv
tb/i2c_status_transfer_sequencer_test.sv
